/* sv/sled_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants of the scancode line editor: key tables,
// special character codes and the decoded key record.
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam int unsigned ROM_SIZE = 73;

    localparam logic [7:0] KEY_LSHIFT   = 8'h04;
    localparam logic [7:0] KEY_RSHIFT   = 8'h05;
    localparam logic [7:0] CH_NONE      = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam logic [7:0] ROM_LOWER [0:ROM_SIZE-1] = '{
        8'h60, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h01, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h02,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h3F, 8'h04, 8'h3F, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h05, 8'h5F, 8'h5F, 8'h20, 8'h5F, 8'h5F,
        8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F,
        8'h5F, 8'h5F, 8'h5F
    };

    localparam logic [7:0] ROM_UPPER [0:ROM_SIZE-1] = '{
        8'h7E, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h01, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h02,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h3F, 8'h04, 8'h3F, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h05, 8'h5F, 8'h5F, 8'h20, 8'h5F, 8'h5F,
        8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F,
        8'h5F, 8'h5F, 8'h5F
    };

    // Decoded key event
    typedef struct packed {
        logic       toggle;     // shift key, press or release
        logic       hit;        // non-shift, non-null press: echo and edit
        logic       backspace;
        logic       newline;
        logic [7:0] ch;
    } sled_key_t;

endpackage
`default_nettype wire

/* sv/sled_keymap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sled_keymap
// Scancode to character lookup through the shift-selected table, and
// classification of the key event.
// ----------------------------------------------------------------------------
module sled_keymap (
    input  wire logic [7:0]       scancode,
    input  wire logic             released,
    input  wire logic             shift,
    output sled_pkg::sled_key_t   key
);
    import sled_pkg::*;

    logic       in_range;
    logic [6:0] idx;
    logic [7:0] ch;
    logic       is_shift;

    assign in_range = (scancode < 8'(ROM_SIZE));
    assign idx      = in_range ? scancode[6:0] : 7'd0;
    assign ch       = shift ? ROM_UPPER[idx] : ROM_LOWER[idx];
    assign is_shift = (ch == KEY_LSHIFT) || (ch == KEY_RSHIFT);

    // Drop out-of-table codes, the null character and plain releases
    assign key.toggle    = in_range && is_shift;
    assign key.hit       = in_range && !is_shift && (ch != CH_NONE) && !released;
    assign key.backspace = (ch == CH_BACKSPACE);
    assign key.newline   = (ch == CH_NEWLINE);
    assign key.ch        = ch;

endmodule
`default_nettype wire

/* sv/scancode_line_editor_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_line_editor_core
// Keyboard scancode decoder with a one-line editor: echoes typed characters,
// keeps the line in a small memory and reads it out on completion.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload                 | items per event
//  --------+---------------------+-------------------------+-----------------
//  in      | in_valid / in_ready | scancode, released      | one key event
//  out     | out_valid/out_ready | kind, character, last   | 0 .. LINE_LEN
//
//  Shift keys and ignored events leave the editor idle; the next item may follow.
//  A typed character is accepted in idle, then its echo is loaded for output.
//  A completed line is then read out character by character through the
//  single registered read port of the line memory.
//  Reset clears the shift flag, the position and the control state; the
//  line memory needs no clearing pass, only written entries are read.
//  A stall on out holds the output register; input waits until idle.
//
module scancode_line_editor_core #(
    parameter int unsigned LINE_LEN = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] scancode,
    input  wire logic       released,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            kind,
    output logic [7:0]      character,
    output logic            last
);
    import sled_pkg::*;

    localparam int unsigned PW = (LINE_LEN > 2) ? $clog2(LINE_LEN) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_READ
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t         state_reg,     state_next;
    logic           shift_reg,     shift_next;
    logic [PW-1:0]  pos_reg,       pos_next;
    logic [PW-1:0]  len_reg,       len_next;
    logic [PW-1:0]  rd_cnt_reg,    rd_cnt_next;
    logic           rd_pend_reg,   rd_pend_next;
    logic [7:0]     echo_ch_reg,   echo_ch_next;
    logic           echo_last_reg, echo_last_next;
    logic           out_valid_reg, out_valid_next;
    logic           kind_reg,      kind_next;
    logic [7:0]     char_reg,      char_next;
    logic           last_reg,      last_next;

    // Line memory: one write port, one registered read port
    logic [7:0]     line_mem [0:LINE_LEN-1];
    logic [7:0]     rd_data_reg;

    sled_key_t      key;
    logic           accept;
    logic           slot_free;
    logic           wr_en;
    logic           rd_en;
    logic           consume;
    logic           issue;
    logic           done;
    logic [PW-1:0]  pos_inc;

    sled_keymap u_keymap (
        .scancode (scancode),
        .released (released),
        .shift    (shift_reg),
        .key      (key)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    // The output register takes a new item when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;
    assign pos_inc   = pos_reg + PW'(1);
    // Complete on a newline or once LINE_LEN-1 characters are held
    assign done      = key.newline || (pos_inc >= PW'(LINE_LEN - 1));

    // Readout: the pending word in rd_data_reg leaves when the slot is free;
    // issue the next read while characters remain and the read register is free or emptying
    assign consume   = (state_reg == ST_READ) && rd_pend_reg && slot_free;
    assign issue     = (state_reg == ST_READ) && (rd_cnt_reg < len_reg)
                       && (!rd_pend_reg || consume);
    assign rd_en     = issue;

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_pend_next   = rd_pend_reg;
        echo_ch_next   = echo_ch_reg;
        echo_last_next = echo_last_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (key.toggle)
                    begin
                        shift_next = !shift_reg;
                    end
                    else if (key.hit)
                    begin
                        echo_ch_next = key.ch;
                        state_next   = ST_ECHO;
                        if (key.backspace && (pos_reg != '0))
                        begin
                            // Step back, echo only
                            pos_next       = pos_reg - PW'(1);
                            echo_last_next = 1'b1;
                        end
                        else
                        begin
                            // Store, and hand the line over when complete
                            wr_en          = 1'b1;
                            echo_last_next = !done;
                            if (done)
                            begin
                                len_next = pos_inc;
                                pos_next = '0;
                            end
                            else
                            begin
                                pos_next = pos_inc;
                            end
                        end
                    end
                end
            end

            ST_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b0;
                    char_next      = echo_ch_reg;
                    last_next      = echo_last_reg;
                    rd_cnt_next    = '0;
                    rd_pend_next   = 1'b0;
                    state_next     = echo_last_reg ? ST_IDLE : ST_READ;
                end
            end

            ST_READ:
            begin
                if (consume)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    char_next      = rd_data_reg;
                    last_next      = (rd_cnt_reg == len_reg);
                    if (rd_cnt_reg == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue)
                begin
                    rd_cnt_next  = rd_cnt_reg + PW'(1);
                    rd_pend_next = 1'b1;
                end
                else if (consume)
                begin
                    rd_pend_next = 1'b0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            echo_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            echo_last_reg <= echo_last_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    // Echo character register: no reset
    always_ff @(posedge clk)
    begin
        echo_ch_reg <= echo_ch_next;
    end

    // Line memory; writes happen only in idle and reads only during readout
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[pos_reg] <= key.ch;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_cnt_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign character = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(LINE_LEN - 2))
        else $error("line position beyond the line limit");

    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rd_cnt_reg <= len_reg))
        else $error("readout ran past the stored line");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (rd_cnt_reg == len_reg)) |=> in_ready)
        else $error("editor not idle after the last line character");

    a_line_mid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind && !last) |-> (state_reg == ST_READ))
        else $error("readout left before the last line character");

    a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_IDLE) && !rd_pend_reg)
        else $error("line memory written during readout");
`endif

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scancode line editor. Key events go in through
// a bursty sender, results come out through a receiver that stalls in
// changing patterns. A shadow of the editor predicts every echo and every
// character of a completed line, and compares each result in order.
// ----------------------------------------------------------------------------
module tb_top;

    import sled_pkg::*;

    localparam int unsigned LINE_LEN       = 64;
    localparam int unsigned KEY_GOAL       = 260;
    localparam int unsigned QUIET_LIMIT    = 1000;

    // Released flag of a key event
    localparam logic KEY_PRESS   = 1'b0;
    localparam logic KEY_RELEASE = 1'b1;

    // Scancodes with a special meaning in the key tables
    localparam logic [7:0] SC_GRAVE     = 8'd0;
    localparam logic [7:0] SC_ESCAPE    = 8'd1;
    localparam logic [7:0] SC_BACKSPACE = 8'd14;
    localparam logic [7:0] SC_TAB       = 8'd15;
    localparam logic [7:0] SC_Q         = 8'd16;
    localparam logic [7:0] SC_ENTER     = 8'd28;
    localparam logic [7:0] SC_CAPS      = 8'd29;
    localparam logic [7:0] SC_LSHIFT    = 8'd42;
    localparam logic [7:0] SC_RSHIFT    = 8'd54;
    localparam logic [7:0] SC_SPACE     = 8'd57;
    localparam logic [7:0] SC_TOP       = 8'd72;
    localparam logic [7:0] SC_MAX       = 8'd255;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG_STALL} rx_mode_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] character;
        logic       last;
    } editor_result_t;

    // ------------------------------------------------------------------------
    // Shadow of the editor: shift flag, line position and line memory,
    // plus the queue of results still owed by the block.
    // ------------------------------------------------------------------------
    class editor_shadow;
        editor_result_t due_chars[$];
        logic           shift_on;
        int unsigned    line_pos;
        logic [7:0]     line_buf [0:63];
        int unsigned    error_count;

        function new();
            shift_on    = 1'b0;
            line_pos    = 0;
            error_count = 0;
        endfunction

        // Apply one accepted key event
        function void take_key(logic [7:0] code, logic rel);
            logic [7:0]  ch;
            bit          done;
            int unsigned i;
            if (code >= ROM_SIZE)
                return;
            ch = shift_on ? ROM_UPPER[code] : ROM_LOWER[code];
            if (ch == KEY_LSHIFT || ch == KEY_RSHIFT)
            begin
                shift_on = !shift_on;
                return;
            end
            if (ch == CH_NONE || rel == KEY_RELEASE)
                return;
            if (line_pos != 0 && ch == CH_BACKSPACE)
            begin
                due_chars.push_back('{1'b0, ch, 1'b1});
                line_pos = line_pos - 1;
                return;
            end
            line_buf[line_pos] = ch;
            line_pos = (line_pos + 1) % 64;
            done = (ch == CH_NEWLINE) || (line_pos >= LINE_LEN - 1);
            due_chars.push_back('{1'b0, ch, !done});
            if (done)
            begin
                for (i = 0; i < line_pos; i++)
                    due_chars.push_back('{1'b1, line_buf[i], (i + 1 == line_pos)});
                line_pos = 0;
            end
        endfunction

        function void match_char(logic k, logic [7:0] c, logic l);
            editor_result_t want;
            if (due_chars.size() == 0)
            begin
                $error("unexpected result: kind %0d character 0x%02h last %0d", k, c, l);
                error_count++;
                return;
            end
            want = due_chars.pop_front();
            if (k !== want.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
                error_count++;
            end
            if (c !== want.character)
            begin
                $error("character mismatch: expected 0x%02h, actual 0x%02h",
                       want.character, c);
                error_count++;
            end
            if (l !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, l);
                error_count++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] scancode;
    logic       released;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       kind;
    logic [7:0] character;
    logic       last;

    editor_shadow shadow = new();

    int unsigned burst_left = 0;
    int unsigned sent_keys  = 0;
    int unsigned quiet      = 0;
    rx_mode_t    rx_mode    = RX_OPEN;
    int unsigned rx_left    = 0;
    int unsigned rx_tick    = 0;

    scancode_line_editor_core #(
        .LINE_LEN (LINE_LEN)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .scancode  (scancode),
        .released  (released),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Receiver: check every accepted result, and stall on a pattern that
    // changes at random (always ready, coin toss, sparse, or
    // long stalls broken by short bursts).
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.match_char(kind, character, last);
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 160);
            rx_tick = 0;
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:       out_ready <= 1'b1;
            RX_COIN:       out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:     out_ready <= (rx_tick % 5 == 0);
            RX_LONG_STALL: out_ready <= (rx_tick % 24 >= 18);
            default:       out_ready <= 1'b1;
        endcase
    end

    // Watchdog: end the run when neither channel moves an item for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Work in bursts: when a burst runs out, drop valid for a random
    // gap, then start a new burst; now and then a long burst with no gap.
    // Hold valid and the payload until the item is accepted.
    // ------------------------------------------------------------------------
    task automatic send_key(input logic [7:0] code, input logic rel);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        scancode <= code;
        released <= rel;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.take_key(code, rel);
        sent_keys++;
        burst_left--;
    endtask

    // Press a key, and release it about half of the time
    task automatic tap_key(input logic [7:0] code);
        send_key(code, KEY_PRESS);
        if ($urandom_range(0, 1))
            send_key(code, KEY_RELEASE);
    endtask

    // Any table entry that stores as a plain character
    function automatic logic [7:0] pick_printable();
        logic [7:0] sc;
        do
            sc = 8'($urandom_range(0, ROM_SIZE - 1));
        while (sc == SC_ESCAPE || sc == SC_BACKSPACE || sc == SC_ENTER ||
               sc == SC_LSHIFT || sc == SC_RSHIFT);
        return sc;
    endfunction

    // Short line: a few characters with edits, shifted runs and the odd
    // broken event, closed by enter
    task automatic type_short_line();
        int unsigned n;
        int unsigned k;
        int unsigned pick;
        logic [7:0]  sh;
        n = $urandom_range(0, 12);
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                tap_key(SC_BACKSPACE);
            end
            else if (pick == 1)
            begin
                sh = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
                send_key(sh, KEY_PRESS);
                repeat ($urandom_range(1, 3)) tap_key(pick_printable());
                send_key(sh, KEY_RELEASE);
            end
            else if (pick == 2)
            begin
                send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                tap_key(pick_printable());
            end
        end
        tap_key(SC_ENTER);
    endtask

    // Long line: type until the editor completes the line on its own
    task automatic type_full_line();
        do
            tap_key(pick_printable());
        while (shadow.line_pos != 0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned seq;
        int unsigned pick;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        scancode = 8'd0;
        released = KEY_PRESS;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: table edges, shift handling, edits and lines
        send_key(SC_MAX,       KEY_PRESS);    // out of the table, all bits set
        send_key(8'(ROM_SIZE), KEY_PRESS);    // first code past the table
        send_key(SC_ESCAPE,    KEY_PRESS);    // zero character
        send_key(SC_BACKSPACE, KEY_PRESS);    // backspace on an empty line stores
        send_key(SC_Q,         KEY_PRESS);
        send_key(SC_Q,         KEY_RELEASE);  // plain release is ignored
        send_key(SC_LSHIFT,    KEY_PRESS);
        send_key(SC_Q,         KEY_PRESS);    // upper case
        send_key(SC_LSHIFT,    KEY_RELEASE);  // release toggles back
        send_key(SC_RSHIFT,    KEY_PRESS);
        send_key(SC_GRAVE,     KEY_PRESS);    // code zero, shifted
        send_key(SC_MAX,       KEY_RELEASE);  // out of range leaves shift alone
        send_key(SC_TOP,       KEY_PRESS);    // last table entry
        send_key(SC_RSHIFT,    KEY_RELEASE);
        send_key(SC_BACKSPACE, KEY_PRESS);    // backspace steps back
        send_key(SC_TAB,       KEY_PRESS);
        send_key(SC_CAPS,      KEY_PRESS);
        send_key(SC_SPACE,     KEY_PRESS);
        send_key(SC_BACKSPACE, KEY_RELEASE);
        send_key(SC_ESCAPE,    KEY_RELEASE);
        send_key(SC_GRAVE,     KEY_RELEASE);  // all-zero code, released
        send_key(SC_ENTER,     KEY_PRESS);    // line read out
        send_key(SC_ENTER,     KEY_PRESS);    // line of a newline alone
        send_key(SC_BACKSPACE, KEY_PRESS);
        send_key(SC_ENTER,     KEY_PRESS);

        // Random part: mostly typed lines, some full lines, some noise
        seq = 0;
        while (sent_keys < KEY_GOAL)
        begin
            pick = $urandom_range(0, 99);
            if (seq == 0 || pick < 10)
                type_full_line();
            else if (pick < 18)
                repeat ($urandom_range(1, 4))
                    send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                type_short_line();
            seq++;
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (shadow.due_chars.size() != 0)
            @(posedge clk);
        repeat (2 * LINE_LEN + 8) @(posedge clk);

        if (shadow.error_count == 0 && shadow.due_chars.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
